>>> design/cwm_pkg.sv
`timescale 1ns / 1ps
package cwm_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_KERNEL   = 5;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int LINE_ROWS = MAX_KERNEL - 1;
  localparam int KIDX_W    = $clog2(MAX_KERNEL);

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SUM_W    = 40;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int WIDX_W   = 3;

  localparam int IMG_W_W     = 11;
  localparam int IMG_H_W     = 13;
  localparam int KSIZE_W     = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_KERNEL_ROWS  = 2'd2,
    CFG_KERNEL_COLS  = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_PIXEL  = 1'b1
  } opcode_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] grid_t;
  typedef sample_t [MAX_KERNEL-1:0] column_t;
  typedef logic [LINE_ROWS*SAMPLE_W-1:0] line_word_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [WIDX_W-1:0]    weight_row;
    logic [WIDX_W-1:0]    weight_col;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] window_sum;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic                    frame_last;
  } out_item_t;

  typedef struct packed {
    logic             produce;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } meta_t;

  typedef struct packed {
    logic              valid;
    logic              is_pixel;
    logic [WIDX_W-1:0] weight_row;
    logic [WIDX_W-1:0] weight_col;
    sample_t           value;
    logic [ADDR_W-1:0] addr;
    meta_t             meta;
  } stage_t;

endpackage

>>> design/cwm_line_ram.sv
`timescale 1ns / 1ps
module cwm_line_ram (
  input  logic                        clk,
  input  logic                        re,
  input  logic [cwm_pkg::ADDR_W-1:0]  raddr,
  output cwm_pkg::line_word_t         rdata,
  input  logic                        we,
  input  logic [cwm_pkg::ADDR_W-1:0]  waddr,
  input  cwm_pkg::line_word_t         wdata
);

  cwm_pkg::line_word_t mem [cwm_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/cwm_window.sv
`timescale 1ns / 1ps
module cwm_window (
  input  logic            clk,
  input  logic            rst,
  input  cwm_pkg::stage_t s0,
  output cwm_pkg::grid_t  window,
  output cwm_pkg::grid_t  kernel,
  output cwm_pkg::meta_t  meta
);

  cwm_pkg::stage_t     s1;
  logic                fwd_hit;
  cwm_pkg::line_word_t fwd_data;
  cwm_pkg::line_word_t ram_rdata;
  cwm_pkg::line_word_t ram_wdata;
  cwm_pkg::line_word_t line_word;
  cwm_pkg::column_t    column;
  logic                ram_re;
  logic                ram_we;

  assign ram_re = s0.valid && s0.is_pixel;
  assign ram_we = s1.valid && s1.is_pixel;

  cwm_line_ram u_ram (
    .clk   (clk),
    .re    (ram_re),
    .raddr (s0.addr),
    .rdata (ram_rdata),
    .we    (ram_we),
    .waddr (s1.addr),
    .wdata (ram_wdata)
  );

  // A write at the same edge as the read of that entry is not yet in the read data.
  always_comb begin
    line_word = fwd_hit ? fwd_data : ram_rdata;
    for (int r = 0; r < cwm_pkg::LINE_ROWS; r++) begin
      column[r] = line_word[r*cwm_pkg::SAMPLE_W +: cwm_pkg::SAMPLE_W];
    end
    column[cwm_pkg::MAX_KERNEL-1] = s1.value;
    for (int r = 0; r < cwm_pkg::LINE_ROWS; r++) begin
      ram_wdata[r*cwm_pkg::SAMPLE_W +: cwm_pkg::SAMPLE_W] = column[r+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1       <= s0;
      fwd_hit  <= ram_we && ram_re && (s1.addr == s0.addr);
    end
    fwd_data <= ram_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      kernel <= '0;
    end else if (s1.valid) begin
      if (s1.is_pixel) begin
        for (int r = 0; r < cwm_pkg::MAX_KERNEL; r++) begin
          for (int c = 0; c < cwm_pkg::MAX_KERNEL - 1; c++) begin
            window[r][c] <= window[r][c+1];
          end
          window[r][cwm_pkg::MAX_KERNEL-1] <= column[r];
        end
      end else if ((s1.weight_row < cwm_pkg::WIDX_W'(cwm_pkg::MAX_KERNEL)) &&
                   (s1.weight_col < cwm_pkg::WIDX_W'(cwm_pkg::MAX_KERNEL))) begin
        kernel[s1.weight_row[cwm_pkg::KIDX_W-1:0]][s1.weight_col[cwm_pkg::KIDX_W-1:0]]
          <= s1.value;
      end
    end
  end

  always_comb begin
    meta         = s1.meta;
    meta.produce = s1.valid && s1.is_pixel && s1.meta.produce;
  end

endmodule

>>> design/cwm_mac.sv
`timescale 1ns / 1ps
module cwm_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  cwm_pkg::meta_t               meta_in,
  input  cwm_pkg::grid_t               window,
  input  cwm_pkg::grid_t               kernel,
  input  logic [cwm_pkg::KSIZE_W-1:0]  kr,
  input  logic [cwm_pkg::KSIZE_W-1:0]  kc,
  output logic                         push,
  output cwm_pkg::out_item_t           push_item
);

  cwm_pkg::grid_t                   opnd;
  logic signed [cwm_pkg::PROD_W-1:0] prod [cwm_pkg::MAX_KERNEL][cwm_pkg::MAX_KERNEL];
  logic signed [cwm_pkg::SUM_W-1:0]  row_sum_next [cwm_pkg::MAX_KERNEL];
  logic signed [cwm_pkg::SUM_W-1:0]  row_sum [cwm_pkg::MAX_KERNEL];
  logic signed [cwm_pkg::SUM_W-1:0]  total_next;
  cwm_pkg::meta_t                   meta2;
  cwm_pkg::meta_t                   meta3;
  cwm_pkg::meta_t                   meta4;

  always_comb begin
    int wr;
    int wc;
    for (int r = 0; r < cwm_pkg::MAX_KERNEL; r++) begin
      for (int c = 0; c < cwm_pkg::MAX_KERNEL; c++) begin
        wr = r + cwm_pkg::MAX_KERNEL - int'(kr);
        wc = c + cwm_pkg::MAX_KERNEL - int'(kc);
        if ((r < int'(kr)) && (c < int'(kc))) begin
          opnd[r][c] = window[cwm_pkg::KIDX_W'(wr)][cwm_pkg::KIDX_W'(wc)];
        end else begin
          opnd[r][c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < cwm_pkg::MAX_KERNEL; r++) begin
      for (int c = 0; c < cwm_pkg::MAX_KERNEL; c++) begin
        prod[r][c] <= $signed(opnd[r][c]) * $signed(kernel[r][c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < cwm_pkg::MAX_KERNEL; r++) begin
      row_sum_next[r] = '0;
      for (int c = 0; c < cwm_pkg::MAX_KERNEL; c++) begin
        row_sum_next[r] = row_sum_next[r] + cwm_pkg::SUM_W'(prod[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    row_sum <= row_sum_next;
  end

  always_comb begin
    total_next = '0;
    for (int r = 0; r < cwm_pkg::MAX_KERNEL; r++) begin
      total_next = total_next + row_sum[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta2.produce <= 1'b0;
      meta3.produce <= 1'b0;
      meta4.produce <= 1'b0;
      push          <= 1'b0;
    end else begin
      meta2 <= meta_in;
      meta3 <= meta2;
      meta4 <= meta3;
      push  <= meta4.produce;
    end
    push_item.window_sum <= total_next;
    push_item.out_row    <= meta4.out_row;
    push_item.out_col    <= meta4.out_col;
    push_item.frame_last <= meta4.frame_last;
  end

endmodule

>>> design/cwm_out_fifo.sv
`timescale 1ns / 1ps
module cwm_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  cwm_pkg::out_item_t              push_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cwm_pkg::out_item_t              out_item,
  output logic [cwm_pkg::FIFO_CNT_W-1:0]  count
);

  cwm_pkg::out_item_t               mem [cwm_pkg::FIFO_DEPTH];
  logic [cwm_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [cwm_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic                             pop;

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + cwm_pkg::FIFO_CNT_W'(push) - cwm_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

>>> design/conv2d_valid_window_mac.sv
`timescale 1ns / 1ps
// Channel   Signals                          Moves
// in        in_valid in_ready in_item        weight write or pixel item
// out       out_valid out_ready out_item     window sum with its coordinates
// cfg       cfg_we cfg_index cfg_data        register write, no handshake
//
// One item is taken per cycle while in_ready is high; each sum is queued before it is offered.
// The line memory is read when a pixel is taken and written back in the next cycle.
// The output queue holds eight items; in_ready drops when queued plus in-flight sums fill it.
// Reset clears the counters, weights and window; the line memory is not cleared.
module conv2d_valid_window_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cwm_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cwm_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [cwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cwm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [cwm_pkg::IMG_W_W-1:0]    image_width;
  logic [cwm_pkg::IMG_H_W-1:0]    image_height;
  logic [cwm_pkg::KSIZE_W-1:0]    kernel_rows;
  logic [cwm_pkg::KSIZE_W-1:0]    kernel_cols;

  logic [cwm_pkg::IMG_W_W-1:0]    w_eff;
  logic [cwm_pkg::IMG_H_W-1:0]    h_eff;
  logic [cwm_pkg::KSIZE_W-1:0]    kr_eff;
  logic [cwm_pkg::KSIZE_W-1:0]    kc_eff;

  logic [cwm_pkg::ADDR_W-1:0]     col_counter;
  logic [cwm_pkg::ROW_W-1:0]      row_counter;
  logic [cwm_pkg::ADDR_W-1:0]     col_counter_next;
  logic [cwm_pkg::ROW_W-1:0]      row_counter_next;
  logic [cwm_pkg::IMG_W_W-1:0]    col_inc;
  logic [cwm_pkg::IMG_H_W-1:0]    row_inc;

  logic                           accept;
  logic                           is_pixel;
  cwm_pkg::stage_t                s0;

  logic [cwm_pkg::FIFO_CNT_W-1:0] inflight;
  logic [cwm_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic                           push;
  cwm_pkg::out_item_t             push_item;
  cwm_pkg::grid_t                 window;
  cwm_pkg::grid_t                 kernel;
  cwm_pkg::meta_t                 s1_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= cwm_pkg::IMG_W_W'(64);
      image_height <= cwm_pkg::IMG_H_W'(64);
      kernel_rows  <= cwm_pkg::KSIZE_W'(3);
      kernel_cols  <= cwm_pkg::KSIZE_W'(3);
    end else if (cfg_we) begin
      case (cwm_pkg::cfg_index_t'(cfg_index))
        cwm_pkg::CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[cwm_pkg::IMG_W_W-1:0];
        end
        cwm_pkg::CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[cwm_pkg::IMG_H_W-1:0];
        end
        cwm_pkg::CFG_KERNEL_ROWS: begin
          kernel_rows <= cfg_data[cwm_pkg::KSIZE_W-1:0];
        end
        cwm_pkg::CFG_KERNEL_COLS: begin
          kernel_cols <= cfg_data[cwm_pkg::KSIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = cwm_pkg::IMG_W_W'(1);
    end else if (image_width > cwm_pkg::IMG_W_W'(cwm_pkg::MAX_WIDTH)) begin
      w_eff = cwm_pkg::IMG_W_W'(cwm_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = cwm_pkg::IMG_H_W'(1);
    end else if (image_height > cwm_pkg::IMG_H_W'(cwm_pkg::HEIGHT_LIMIT)) begin
      h_eff = cwm_pkg::IMG_H_W'(cwm_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = image_height;
    end
    if (kernel_rows == '0) begin
      kr_eff = cwm_pkg::KSIZE_W'(1);
    end else if (kernel_rows > cwm_pkg::KSIZE_W'(cwm_pkg::MAX_KERNEL)) begin
      kr_eff = cwm_pkg::KSIZE_W'(cwm_pkg::MAX_KERNEL);
    end else begin
      kr_eff = kernel_rows;
    end
    if (kernel_cols == '0) begin
      kc_eff = cwm_pkg::KSIZE_W'(1);
    end else if (kernel_cols > cwm_pkg::KSIZE_W'(cwm_pkg::MAX_KERNEL)) begin
      kc_eff = cwm_pkg::KSIZE_W'(cwm_pkg::MAX_KERNEL);
    end else begin
      kc_eff = kernel_cols;
    end
  end

  assign in_ready = ({1'b0, fifo_count} + {1'b0, inflight}) <
                    (cwm_pkg::FIFO_CNT_W + 1)'(cwm_pkg::FIFO_DEPTH);
  assign accept   = in_valid && in_ready;
  assign is_pixel = (in_item.opcode == cwm_pkg::OP_PIXEL);

  always_comb begin
    col_inc = cwm_pkg::IMG_W_W'(col_counter) + cwm_pkg::IMG_W_W'(1);
    row_inc = cwm_pkg::IMG_H_W'(row_counter) + cwm_pkg::IMG_H_W'(1);

    s0.valid           = accept;
    s0.is_pixel        = is_pixel;
    s0.weight_row      = in_item.weight_row;
    s0.weight_col      = in_item.weight_col;
    s0.value           = in_item.sample_value;
    s0.addr            = col_counter;
    s0.meta.produce    = (row_inc >= cwm_pkg::IMG_H_W'(kr_eff)) &&
                         (col_inc >= cwm_pkg::IMG_W_W'(kc_eff));
    s0.meta.out_row    = cwm_pkg::ROW_W'(row_inc - cwm_pkg::IMG_H_W'(kr_eff));
    s0.meta.out_col    = cwm_pkg::COL_W'(col_inc - cwm_pkg::IMG_W_W'(kc_eff));
    s0.meta.frame_last = (row_inc == h_eff) && (col_inc == w_eff);

    col_counter_next = cwm_pkg::ADDR_W'(col_inc);
    row_counter_next = row_counter;
    if (col_inc >= w_eff) begin
      col_counter_next = '0;
      if (row_inc >= h_eff) begin
        row_counter_next = '0;
      end else begin
        row_counter_next = cwm_pkg::ROW_W'(row_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
      inflight    <= '0;
    end else begin
      if (accept && is_pixel) begin
        col_counter <= col_counter_next;
        row_counter <= row_counter_next;
      end
      inflight <= inflight
                + cwm_pkg::FIFO_CNT_W'(accept && is_pixel && s0.meta.produce)
                - cwm_pkg::FIFO_CNT_W'(push);
    end
  end

  cwm_window u_window (
    .clk    (clk),
    .rst    (rst),
    .s0     (s0),
    .window (window),
    .kernel (kernel),
    .meta   (s1_meta)
  );

  cwm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .meta_in   (s1_meta),
    .window    (window),
    .kernel    (kernel),
    .kr        (kr_eff),
    .kc        (kc_eff),
    .push      (push),
    .push_item (push_item)
  );

  cwm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .count     (fifo_count)
  );

endmodule

>>> dv/tb_conv2d_valid_window_mac.sv
`timescale 1ns / 1ps
module tb_conv2d_valid_window_mac;
  import cwm_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_GAP = 40;
  localparam longint TIMEOUT_NS = 64'd14_400_000;

  class sum_tracker;
    int unsigned width_reg, height_reg, krows_reg, kcols_reg;
    int row_pos, col_pos;
    sample_t line_mem [LINE_ROWS][MAX_WIDTH];
    sample_t coef [MAX_KERNEL][MAX_KERNEL];
    sample_t win [MAX_KERNEL][MAX_KERNEL];
    out_item_t sums_due [$];
    int mismatches, n_pixels, n_weights, n_checked;

    function new();
      width_reg = 64;
      height_reg = 64;
      krows_reg = 3;
      kcols_reg = 3;
      foreach (line_mem[r, c]) line_mem[r][c] = '0;
      foreach (coef[r, c]) begin
        coef[r][c] = '0;
        win[r][c] = '0;
      end
    endfunction

    function int bounded(int unsigned v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_config(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[IMG_H_W-1:0];
        CFG_KERNEL_ROWS:  krows_reg  = data[KSIZE_W-1:0];
        CFG_KERNEL_COLS:  kcols_reg  = data[KSIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      sample_t column [MAX_KERNEL];
      int w, h, kr, kc, x, y, xi;
      longint acc;
      out_item_t res;
      w = bounded(width_reg, MAX_WIDTH);
      h = bounded(height_reg, HEIGHT_LIMIT);
      kr = bounded(krows_reg, MAX_KERNEL);
      kc = bounded(kcols_reg, MAX_KERNEL);
      if (it.opcode == OP_WEIGHT) begin
        n_weights++;
        if (it.weight_row < MAX_KERNEL && it.weight_col < MAX_KERNEL)
          coef[it.weight_row][it.weight_col] = it.sample_value;
        return;
      end
      n_pixels++;
      x = col_pos;
      y = row_pos;
      xi = x % MAX_WIDTH;
      for (int r = 0; r < LINE_ROWS; r++) column[r] = line_mem[r][xi];
      column[MAX_KERNEL-1] = it.sample_value;
      for (int r = 0; r < LINE_ROWS; r++) line_mem[r][xi] = column[r+1];
      for (int r = 0; r < MAX_KERNEL; r++) begin
        for (int c = 0; c < MAX_KERNEL - 1; c++) win[r][c] = win[r][c+1];
        win[r][MAX_KERNEL-1] = column[r];
      end
      if (y + 1 >= kr && x + 1 >= kc) begin
        acc = 0;
        for (int r = 0; r < kr; r++)
          for (int c = 0; c < kc; c++)
            acc += longint'(win[MAX_KERNEL-kr+r][MAX_KERNEL-kc+c]) * longint'(coef[r][c]);
        res.window_sum = acc[SUM_W-1:0];
        res.out_row = ROW_W'(y + 1 - kr);
        res.out_col = COL_W'(x + 1 - kc);
        res.frame_last = (y == h - 1 && x == w - 1);
        sums_due.push_back(res);
      end
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
      col_pos = x;
      row_pos = y;
    endfunction

    function void check_sum(out_item_t got);
      out_item_t want;
      n_checked++;
      if (sums_due.size() == 0) begin
        $error("window sum %0d at row %0d col %0d arrived with none expected",
               got.window_sum, got.out_row, got.out_col);
        mismatches++;
        return;
      end
      want = sums_due.pop_front();
      if (got.window_sum !== want.window_sum) begin
        $error("window_sum: expected %0d, got %0d", want.window_sum, got.window_sum);
        mismatches++;
      end
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        mismatches++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        mismatches++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct = 12;
  int recv_idle_pct = 81;
  bit hold_off_req;
  sum_tracker tracker = new();

  conv2d_valid_window_mac dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.note_config(cfg_index_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) tracker.take_item(in_item);
      if (out_valid && out_ready) tracker.check_sum(out_item);
    end
  end

  // The long hold-off lets the output queue fill so that in_ready drops.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t weight_item(int unsigned row, int unsigned col, sample_t v);
    in_item_t it;
    it.opcode = OP_WEIGHT;
    it.weight_row = WIDX_W'(row);
    it.weight_col = WIDX_W'(col);
    it.sample_value = v;
    return it;
  endfunction

  function automatic in_item_t random_weight();
    if ($urandom_range(9) < 8)
      return weight_item($urandom_range(MAX_KERNEL - 1), $urandom_range(MAX_KERNEL - 1),
                         pick_sample());
    return weight_item($urandom_range(7), $urandom_range(7), pick_sample());
  endfunction

  function automatic in_item_t pixel_item(sample_t v);
    in_item_t it;
    it.opcode = OP_PIXEL;
    it.weight_row = WIDX_W'($urandom_range(7));
    it.weight_col = WIDX_W'($urandom_range(7));
    it.sample_value = v;
    return it;
  endfunction

  function automatic int frame_len(int unsigned w_raw, int unsigned h_raw);
    int w, h;
    w = (w_raw == 0) ? 1 : ((w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw);
    h = (h_raw == 0) ? 1 : ((h_raw > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_raw);
    return w * h;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pixels(int count, int weight_pct);
    repeat (count) begin
      if ($urandom_range(99) < weight_pct) send_item(random_weight());
      send_item(pixel_item(pick_sample()));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (tracker.sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned kr, int unsigned kc);
    cfg_index_t regs [4];
    int unsigned vals [4];
    regs = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_KERNEL_ROWS, CFG_KERNEL_COLS};
    vals = '{w, h, kr, kc};
    wait_drained();
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    sample_t dir_px [12];
    int unsigned w_raw, h_raw, kr_raw, kc_raw;
    int base, done, settings;
    dir_px = '{-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 0, -1, 1, 256};
    settings = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extreme weights, a write to the last cell, then writes whose row or column is out of range.
    send_item(weight_item(0, 0, 16'h7FFF));
    send_item(weight_item(0, 1, 16'h8000));
    send_item(weight_item(1, 0, 16'h8000));
    send_item(weight_item(1, 1, 16'hFFFF));
    send_item(weight_item(4, 4, 16'sd12345));
    send_item(weight_item(5, 0, 16'sd100));
    send_item(weight_item(0, 5, 16'sd200));
    send_item(weight_item(7, 7, -16'sd5));

    // Stop inside a frame, then shrink both bounds to or below the counters.
    set_frame(4, 4, 2, 2);
    for (int i = 0; i < 11; i++) send_item(pixel_item(dir_px[i]));
    set_frame(2, 2, 2, 2);
    send_item(pixel_item(dir_px[11]));

    // A kernel larger than the image gives no sums.
    set_frame(2, 2, 3, 3);
    send_pixels(4, 0);

    // Zero in every register counts as one.
    set_frame(0, 0, 0, 0);
    send_pixels(2, 0);

    set_frame(8, 8, 1, 1);
    hold_off_req = 1'b1;
    send_pixels(64, 0);

    // Oversized registers saturate; the run stops inside a row.
    set_frame(0, 8191, 0, 0);
    send_pixels(16, 0);
    set_frame(2047, 8191, 0, 7);
    for (int c = 0; c < MAX_KERNEL; c++) send_item(weight_item(0, c, pick_sample()));
    send_pixels(48, 0);

    // A one-pixel frame wraps both counters from beyond their bounds.
    set_frame(1, 1, 1, 1);
    send_pixels(1, 0);
    settings += 8;

    base = tracker.n_pixels + tracker.n_weights;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      case ((done * 3) / RANDOM_ITEMS)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case ($urandom_range(9))
        0: w_raw = 0;
        1: w_raw = $urandom_range(13, 40);
        default: w_raw = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
        0: h_raw = 0;
        1: h_raw = $urandom_range(9, 16);
        default: h_raw = $urandom_range(1, 8);
      endcase
      kr_raw = $urandom_range(7);
      kc_raw = $urandom_range(7);
      set_frame(w_raw, h_raw, kr_raw, kc_raw);
      settings++;
      repeat ($urandom_range(3, 12)) send_item(random_weight());
      repeat ($urandom_range(1, 3)) send_pixels(frame_len(w_raw, h_raw), 8);
      done = tracker.n_pixels + tracker.n_weights - base;
    end

    wait_drained();
    $display("Checked %0d window sums from %0d pixel items and %0d weight writes",
             tracker.n_checked, tracker.n_pixels, tracker.n_weights);
    $display("over %0d register settings, including saturated and zero ones.", settings);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/cwm_pkg.sv
design/cwm_line_ram.sv
design/cwm_window.sv
design/cwm_mac.sv
design/cwm_out_fifo.sv
design/conv2d_valid_window_mac.sv
dv/tb_conv2d_valid_window_mac.sv
